@@ src/tpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_pkg: shared types and constants of the telemetry packet framer
// Slot codes, conversion constants, frame layout and controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int NUM_FIELDS  = 15;
  localparam int MODE_W      = 4;
  localparam int SAMPLE_W    = 48;
  localparam int WORD_W      = 32;
  localparam int SHORT_W     = 16;
  localparam int POS_W       = 6;
  localparam int FIXED_BYTES = 41;  // frame length without padding

  // Slot codes
  localparam logic [MODE_W-1:0] SLOT_TIME = 4'd0;
  localparam logic [MODE_W-1:0] SLOT_LAT  = 4'd1;
  localparam logic [MODE_W-1:0] SLOT_LNG  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_EMIT = 4'd15;

  // Frame markers
  localparam logic [7:0] HEADER_BYTE = 8'h43;
  localparam logic [7:0] FOOTER_BYTE = 8'h2A;
  localparam logic [15:0] TS_RESET   = 16'd1234;

  // Conversion constants
  localparam logic [16:0] MUL_TIME   = 17'd100;
  localparam logic [16:0] MUL_LATLNG = 17'd100000;
  localparam logic [SAMPLE_W-1:0] ROUND_HALF = 48'd32768;

  // Frame layout: positions of the long and short field regions
  localparam logic [POS_W-1:0] POS_LONG  = 6'd3;
  localparam logic [POS_W-1:0] POS_SHORT = 6'd15;
  localparam logic [POS_W-1:0] POS_PAD   = 6'd39;
  localparam logic [3:0]       FIRST_SHORT_SLOT = 4'd3;

  // Right shift turning Q31.16 * 2^k into an integer, for 16-bit slots
  function automatic logic [3:0] slot_shift(input logic [MODE_W-1:0] slot);
    logic [3:0] s;
    unique case (slot)
      4'd3, 4'd7, 4'd8, 4'd9:    s = 4'd12;  // temperature, gyro
      4'd4, 4'd5, 4'd6:          s = 4'd6;   // accel
      4'd10, 4'd11, 4'd12:       s = 4'd4;   // magnetometer
      4'd13:                     s = 4'd8;   // pressure
      4'd14:                     s = 4'd14;  // altitude
      default:                   s = 4'd0;   // 32-bit slots, emit
    endcase
    return s;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;     // latch the load request
    logic absolute;    // form the multiplier operand
    logic multiply;    // register the product
    logic write;       // finish the conversion and store it
    logic emit_start;  // restart position and checksum
    logic emit_step;   // one frame byte taken
  } tpf_cmd_t;

  typedef struct packed {
    logic emit_last;   // position sits on the checksum byte
  } tpf_status_t;

endpackage

@@ src/tpf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_in_if: request channel of the telemetry packet framer
// Valid/ready handshake carrying the mode and the Q31.16 sample.
// ----------------------------------------------------------------------------
interface tpf_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic signed [47:0] sample_value;

  modport source (output valid, output mode, output sample_value, input ready);
  modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

@@ src/tpf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_out_if: frame byte channel of the telemetry packet framer
// Valid/ready handshake carrying one frame byte and its end marker.
// ----------------------------------------------------------------------------
interface tpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

@@ src/telemetry_packet_framer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_framer_unit: telemetry frame builder
// Loads fifteen converted measurements and emits them as one framed,
// checksummed byte stream.
// ----------------------------------------------------------------------------
// A load request (mode 0-14) is taken while idle and then occupies the
// block through operand forming, one pass through the shared 48x17
// constant multiplier, and the rounding/shift and store write. An emit
// request (mode 15) streams 41 + PAD_BYTES bytes at one byte per cycle
// while out_chan.ready is high, paced by the byte position counter; the
// checksum byte carries last_byte. The field store is cleared directly by
// reset, with no clearing pass. The timestamp word is written through
// cfg_we/cfg_wdata and should only change while idle.
module telemetry_packet_framer_unit
  import tpf_pkg::*;
#(
  parameter int PAD_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  tpf_in_if.sink      in_chan,
  tpf_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  tpf_cmd_t    cmd;
  tpf_status_t status;

  tpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_emit   (in_chan.mode == MODE_EMIT),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tpf_datapath #(
    .PAD_BYTES (PAD_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_chan.mode),
    .in_sample  (in_chan.sample_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status),
    .frame_byte (out_chan.frame_byte),
    .last_byte  (out_chan.last_byte)
  );

endmodule

@@ src/tpf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_ctrl: controller of the telemetry packet framer
// Sequences a load through operand, multiply and write, or runs an emit.
// ----------------------------------------------------------------------------
module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_emit,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  tpf_status_t status,
  output tpf_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_emit ? ST_EMIT : ST_ABS;
        end
      end
      ST_ABS:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      ST_EMIT: begin
        if (out_ready && status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture    = in_valid && !in_emit;
        cmd.emit_start = in_valid && in_emit;
      end
      ST_ABS:   cmd.absolute = 1'b1;
      ST_MUL:   cmd.multiply = 1'b1;
      ST_WRITE: cmd.write    = 1'b1;
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = out_ready;
      end
      default: ;
    endcase
  end

endmodule

@@ src/tpf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_datapath: conversion, field store and frame byte selection
// Converts one sample per load through a shared constant multiplier and
// serializes the stored fields with a running XOR checksum.
// ----------------------------------------------------------------------------
module tpf_datapath
  import tpf_pkg::*;
#(
  parameter int PAD_BYTES = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,
  input  tpf_cmd_t                   cmd,
  output tpf_status_t                status,
  output logic [7:0]                 frame_byte,
  output logic                       last_byte
);

  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FIXED_BYTES + PAD_BYTES - 1);
  localparam logic [POS_W-1:0] FOOTER_POS = POS_W'(FIXED_BYTES + PAD_BYTES - 2);

  logic [15:0]          ts_r;
  logic [MODE_W-1:0]    mode_r;
  logic [SAMPLE_W-1:0]  raw_r;
  logic [SAMPLE_W-1:0]  op_r;
  logic                 neg_r;
  logic [SAMPLE_W-1:0]  prod_r;
  logic [WORD_W-1:0]    fields_r [NUM_FIELDS];
  logic [POS_W-1:0]     pos_r;
  logic [7:0]           xor_r;

  // Timestamp register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
    end else if (cfg_we) begin
      ts_r <= cfg_wdata;
    end
  end

  // Load request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      raw_r  <= in_sample;
    end
  end

  // Operand: magnitude for all but time, which keeps the signed value
  logic [SAMPLE_W-1:0] mag;
  assign mag = raw_r[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw_r) : raw_r;

  always_ff @(posedge clk) begin
    if (cmd.absolute) begin
      op_r  <= (mode_r == SLOT_TIME) ? raw_r : mag;
      neg_r <= raw_r[SAMPLE_W-1];
    end
  end

  // Shared constant multiplier, low 48 bits only
  logic [16:0] mul_k;
  assign mul_k = (mode_r == SLOT_TIME) ? MUL_TIME : MUL_LATLNG;

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      prod_r <= op_r * SAMPLE_W'(mul_k);
    end
  end

  // Final conversion
  logic [SAMPLE_W-1:0] rounded;
  logic [SAMPLE_W-1:0] shifted;
  logic [SHORT_W-1:0]  short_word;
  logic [WORD_W-1:0]   conv_word;

  always_comb begin
    rounded    = prod_r + ROUND_HALF;
    shifted    = op_r >> slot_shift(mode_r);
    short_word = neg_r ? (SHORT_W'(0) - shifted[SHORT_W-1:0]) : shifted[SHORT_W-1:0];
    if (mode_r == SLOT_TIME || mode_r == SLOT_LAT || mode_r == SLOT_LNG) begin
      conv_word = rounded[SAMPLE_W-1:16];
    end else begin
      conv_word = {{(WORD_W-SHORT_W){1'b0}}, short_word};
    end
  end

  // Field store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fields_r[i] <= '0;
      end
    end else if (cmd.write && mode_r != MODE_EMIT) begin
      fields_r[mode_r] <= conv_word;
    end
  end

  // Emit position and running checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
    end else if (cmd.emit_start) begin
      pos_r <= '0;
      xor_r <= '0;
    end else if (cmd.emit_step) begin
      pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
      xor_r <= (pos_r == LAST_POS) ? '0 : xor_r ^ frame_byte;
    end
  end

  // Byte selection by position
  logic [POS_W-1:0]  p_long, p_short;
  logic [3:0]        long_idx, short_idx;
  logic [WORD_W-1:0] long_word, short_sel;

  always_comb begin
    p_long    = pos_r - POS_LONG;
    p_short   = pos_r - POS_SHORT;
    long_idx  = {2'b00, p_long[3:2]};
    short_idx = FIRST_SHORT_SLOT + p_short[4:1];
    long_word = fields_r[long_idx];
    short_sel = fields_r[short_idx];
    priority if (pos_r == '0) begin
      frame_byte = HEADER_BYTE;
    end else if (pos_r == 6'd1) begin
      frame_byte = ts_r[15:8];
    end else if (pos_r == 6'd2) begin
      frame_byte = ts_r[7:0];
    end else if (pos_r < POS_SHORT) begin
      unique case (p_long[1:0])
        2'd0:    frame_byte = long_word[31:24];
        2'd1:    frame_byte = long_word[23:16];
        2'd2:    frame_byte = long_word[15:8];
        default: frame_byte = long_word[7:0];
      endcase
    end else if (pos_r < POS_PAD) begin
      frame_byte = p_short[0] ? short_sel[7:0] : short_sel[15:8];
    end else if (pos_r == LAST_POS) begin
      frame_byte = xor_r;
    end else if (pos_r == FOOTER_POS) begin
      frame_byte = FOOTER_BYTE;
    end else begin
      frame_byte = 8'h00;
    end
  end

  assign last_byte        = (pos_r == LAST_POS);
  assign status.emit_last = (pos_r == LAST_POS);

endmodule

@@ src/tpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_checker: port-level checks of the telemetry packet framer
// Watches the request and byte channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tpf_checker
  import tpf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [3:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  // No new request is taken while a frame is streaming
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request ready while frame in flight");

  // An emit request starts a frame with the header byte
  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == MODE_EMIT) |=>
      (out_valid && out_frame_byte == HEADER_BYTE && !out_last_byte))
    else $error("frame did not open with header");

  // The checksum byte closes the frame
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |=> !out_valid)
    else $error("bytes after end of frame");

  // A stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_frame_byte) && $stable(out_last_byte)))
    else $error("stalled frame byte changed");

endmodule

bind telemetry_packet_framer_unit tpf_checker u_tpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_mode        (in_chan.mode),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_frame_byte (out_chan.frame_byte),
  .out_last_byte  (out_chan.last_byte)
);
